@@ src/ddms_pkg.sv @@
package ddms_pkg;

	// Motor bridge codes
	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SLEW_STEP       = 2'd0,
		REG_MIN_DUTY        = 2'd1,
		REG_SERVO_ON_ANGLE  = 2'd2,
		REG_SERVO_OFF_ANGLE = 2'd3
	} reg_idx_t;

	localparam logic [7:0] SLEW_STEP_RST       = 8'd10;
	localparam logic [7:0] MIN_DUTY_RST        = 8'd50;
	localparam logic [7:0] SERVO_ON_ANGLE_RST  = 8'd90;
	localparam logic [7:0] SERVO_OFF_ANGLE_RST = 8'd0;

	localparam logic [7:0] DUTY_FULL = 8'd255;

	typedef logic signed [8:0] speed_t;

	// Mix one joystick sample into a clamped motor target.
	// Turn is half the left/right difference, rounded toward zero.
	function automatic speed_t mix_target(
		input logic [7:0] fwd,
		input logic [7:0] rev,
		input logic [7:0] lft,
		input logic [7:0] rgt,
		input logic       is_left
	);
		logic signed [9:0]  base;
		logic signed [9:0]  diff;
		logic signed [9:0]  adj;
		logic signed [9:0]  turn;
		logic signed [10:0] tgt;
		speed_t             res;
		base = $signed({2'b00, fwd}) - $signed({2'b00, rev});
		diff = $signed({2'b00, rgt}) - $signed({2'b00, lft});
		adj  = diff + $signed({9'b0, diff[9]});
		turn = adj >>> 1;
		if (is_left) begin
			tgt = $signed({base[9], base}) + $signed({turn[9], turn});
		end else begin
			tgt = $signed({base[9], base}) - $signed({turn[9], turn});
		end
		if (tgt > 11'sd255) begin
			res = 9'sd255;
		end else if (tgt < -11'sd255) begin
			res = -9'sd255;
		end else begin
			res = tgt[8:0];
		end
		return res;
	endfunction

	// Move a stored speed toward its target by at most one step.
	function automatic speed_t slew_toward(
		input speed_t     cur,
		input speed_t     tgt,
		input logic [7:0] step
	);
		logic signed [9:0] diff;
		logic signed [9:0] stp;
		logic signed [9:0] nxt;
		speed_t            res;
		diff = $signed({tgt[8], tgt}) - $signed({cur[8], cur});
		stp  = $signed({2'b00, step});
		if (diff > stp) begin
			nxt = $signed({cur[8], cur}) + stp;
			res = nxt[8:0];
		end else if (diff < -stp) begin
			nxt = $signed({cur[8], cur}) - stp;
			res = nxt[8:0];
		end else begin
			res = tgt;
		end
		return res;
	endfunction

	// Scale a speed magnitude into a duty: m*(255-min)/255 + min.
	// The divide by 255 is exact for products below 2^16.
	function automatic logic [7:0] speed_duty(
		input speed_t     spd,
		input logic [7:0] min_duty
	);
		speed_t      neg;
		logic [7:0]  mag;
		logic [15:0] prod;
		logic [16:0] scl;
		logic [7:0]  res;
		neg  = -spd;
		mag  = spd[8] ? neg[7:0] : spd[7:0];
		prod = mag * (DUTY_FULL - min_duty);
		scl  = {1'b0, prod} + 17'd1 + {9'b0, prod[15:8]};
		if (mag == 8'd0) begin
			res = 8'd0;
		end else begin
			res = scl[15:8] + min_duty;
		end
		return res;
	endfunction

	function automatic dir_t speed_dir(input speed_t spd);
		dir_t res;
		if (spd == 9'sd0) begin
			res = DIR_STOP;
		end else if (spd[8]) begin
			res = DIR_REV;
		end else begin
			res = DIR_FWD;
		end
		return res;
	endfunction

endpackage

@@ src/differential_drive_mixer_slew_core.sv @@
// Arcade-style differential drive mixer with slew-rate limit. Each joystick sample
// (forward, reverse, left, right levels and a trigger bit) is mixed into left and
// right motor targets, the stored motor speeds step toward those targets by at most
// slew_step, and each speed is turned into a direction code and a scaled PWM duty;
// the servo angle follows the trigger. The block takes one sample per clock while
// out_stall is low and gives one result per sample, through an input register, the
// speed registers (updated as a sample leaves the input register), and the result
// register, which computes duty with one 8x8 multiply per motor. The user writes
// registers through the cfg port (index 0 slew_step, 1 min_duty, 2 servo_on_angle, 3
// servo_off_angle) only while the block is idle; the block does not enforce it. cfg_ready is always high.
module differential_drive_mixer_slew_core (
	input  logic       clk,
	input  logic       arst_n,
	// sample channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] forward_level,
	input  logic [7:0] reverse_level,
	input  logic [7:0] left_level,
	input  logic [7:0] right_level,
	input  logic       trigger,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] left_duty,
	output logic [1:0] left_direction,
	output logic [7:0] right_duty,
	output logic [1:0] right_direction,
	output logic [7:0] servo_angle,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import ddms_pkg::*;

	logic [7:0] slew_step_q;
	logic [7:0] min_duty_q;
	logic [7:0] servo_on_q;
	logic [7:0] servo_off_q;

	logic       valid_s1;
	logic [7:0] fwd_s1;
	logic [7:0] rev_s1;
	logic [7:0] lft_s1;
	logic [7:0] rgt_s1;
	logic       trig_s1;

	logic       valid_s2;
	speed_t     left_speed_q;
	speed_t     right_speed_q;
	logic [7:0] servo_s2;

	logic       out_valid_q;
	logic [7:0] left_duty_q;
	dir_t       left_dir_q;
	logic [7:0] right_duty_q;
	dir_t       right_dir_q;
	logic [7:0] servo_q;

	logic       adv_out;
	logic       adv_s2;
	logic       adv_s1;
	speed_t     left_tgt;
	speed_t     right_tgt;

	// Pipeline advance: each stage moves when the next one is empty or leaving
	assign adv_out  = valid_s2 && (!out_valid_q || !out_stall);
	assign adv_s2   = valid_s1 && (!valid_s2 || adv_out);
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slew_step_q <= SLEW_STEP_RST;
			min_duty_q  <= MIN_DUTY_RST;
			servo_on_q  <= SERVO_ON_ANGLE_RST;
			servo_off_q <= SERVO_OFF_ANGLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SLEW_STEP:       slew_step_q <= cfg_data;
				REG_MIN_DUTY:        min_duty_q  <= cfg_data;
				REG_SERVO_ON_ANGLE:  servo_on_q  <= cfg_data;
				REG_SERVO_OFF_ANGLE: servo_off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: hold the accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			fwd_s1  <= forward_level;
			rev_s1  <= reverse_level;
			lft_s1  <= left_level;
			rgt_s1  <= right_level;
			trig_s1 <= trigger;
		end
	end

	// Mix the held sample into clamped targets
	assign left_tgt  = mix_target(fwd_s1, rev_s1, lft_s1, rgt_s1, 1'b1);
	assign right_tgt = mix_target(fwd_s1, rev_s1, lft_s1, rgt_s1, 1'b0);

	// Speed state: advance toward targets once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			left_speed_q  <= '0;
			right_speed_q <= '0;
		end else begin
			if (adv_s2) begin
				valid_s2      <= 1'b1;
				left_speed_q  <= slew_toward(left_speed_q, left_tgt, slew_step_q);
				right_speed_q <= slew_toward(right_speed_q, right_tgt, slew_step_q);
			end else if (adv_out) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			servo_s2 <= trig_s1 ? servo_on_q : servo_off_q;
		end
	end

	// Result register: drop the transaction when taken, load the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			left_duty_q  <= speed_duty(left_speed_q, min_duty_q);
			left_dir_q   <= speed_dir(left_speed_q);
			right_duty_q <= speed_duty(right_speed_q, min_duty_q);
			right_dir_q  <= speed_dir(right_speed_q);
			servo_q      <= servo_s2;
		end
	end

	assign out_valid       = out_valid_q;
	assign left_duty       = left_duty_q;
	assign left_direction  = left_dir_q;
	assign right_duty      = right_duty_q;
	assign right_direction = right_dir_q;
	assign servo_angle     = servo_q;

endmodule
